// File: sv/assert_macros.svh
// Assertion helpers for the RTL.
// Each macro expands to one labeled concurrent assertion that is clocked on
// the rising edge and switched off while the synchronous reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ctdp_pkg.sv
// ============================================================================
// ctdp_pkg
// Types and constants of the change tracking data pool: request and response
// beats, operation codes and default sizes.
// ============================================================================
`default_nettype none

package ctdp_pkg;

    localparam int BYTE_DEPTH_DEF = 256;
    localparam int FLAG_BITS_DEF  = 256;

    // Operation codes carried in the mode field of a request.
    localparam logic [3:0] MODE_BYTE_WR    = 4'd0;
    localparam logic [3:0] MODE_WORD_WR    = 4'd1;
    localparam logic [3:0] MODE_LONG_WR    = 4'd2;
    localparam logic [3:0] MODE_BIT_WR     = 4'd3;
    localparam logic [3:0] MODE_FBYTE_WR   = 4'd4;
    localparam logic [3:0] MODE_FBYTE_FTCH = 4'd5;
    localparam logic [3:0] MODE_BYTE_RD    = 4'd6;
    localparam logic [3:0] MODE_CHECK      = 4'd7;
    localparam logic [3:0] MODE_CLEAR_MARK = 4'd8;

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  address;
        logic [31:0] value;
        logic        force_req;
        logic [7:0]  reload_value;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       changed;
        logic       any_changed;
    } t_rsp;

endpackage

`default_nettype wire

// File: sv/change_tracking_data_pool_unit.sv
// ============================================================================
// change_tracking_data_pool_unit
// Shadow data store with change marks. A byte area keeps one change mark per
// byte and a flag area keeps one change mark per flag bit. Requests arrive
// one at a time and each returns exactly one response beat. A request is
// taken only in the idle state and passes through the work state, which steps
// through N entries, and the done state before the next is taken. N is 1 for
// byte, bit, flag, read, check and clear-mark requests, 2 for a word write
// and 4 for a long write. N is set by the single write port of the byte
// memory, which stores one byte per cycle while the read of the following
// byte is already in flight. A finished response sits in an output register,
// so the next request is accepted while that beat still waits downstream.
// After reset a clearing pass over max(BYTE_DEPTH, ceil(FLAG_BITS / 8))
// addresses zeroes both memories; requests are stalled during that pass.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module change_tracking_data_pool_unit #(
    parameter int BYTE_DEPTH = ctdp_pkg::BYTE_DEPTH_DEF,
    parameter int FLAG_BITS  = ctdp_pkg::FLAG_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_stall,
    input  wire ctdp_pkg::t_req  i_req,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_stall,
    output ctdp_pkg::t_rsp       o_rsp
);

    localparam int FLAG_BYTES = FLAG_BITS / 8;
    localparam int FLAG_DEPTH = (FLAG_BITS + 7) / 8;
    localparam int AW         = $clog2(BYTE_DEPTH);
    localparam int FW         = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;
    localparam int MAXD       = (BYTE_DEPTH > FLAG_DEPTH) ? BYTE_DEPTH : FLAG_DEPTH;
    localparam int CLRW       = $clog2(MAXD);
    localparam int CW         = $clog2(BYTE_DEPTH + FLAG_BITS + 1);
    // Reciprocals for the wrap of small addresses by a constant.
    localparam int RECIP_B    = (65536 + BYTE_DEPTH - 1) / BYTE_DEPTH;
    localparam int RECIP_FB   = (65536 + FLAG_BITS - 1) / FLAG_BITS;
    localparam int RECIP_FY   = (65536 + FLAG_BYTES - 1) / FLAG_BYTES;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WORK  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    // x mod d for x below 1024: the quotient estimate is at most one too
    // large, so a single correction step suffices.
    function automatic logic [11:0] wrap_index(input logic [9:0] x, input int d,
                                               input int recip);
        int xi;
        int q;
        int r;
        xi = int'(x);
        q  = (xi * recip) >>> 16;
        r  = xi - q * d;
        if (r < 0) begin
            r = r + d;
        end
        return r[11:0];
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] x);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'd0, x[k]};
        end
        return n;
    endfunction

    // Memories: byte area entry is {mark, data}, flag area entry is {bits, marks}.
    logic [8:0]  r_bmem [BYTE_DEPTH];
    logic [15:0] r_fmem [FLAG_DEPTH];
    logic [8:0]  r_bmem_q;
    logic [15:0] r_fmem_q;

    t_state          r_state, n_state;
    logic [CLRW-1:0] r_clr, n_clr;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_left, n_left;
    logic            r_rsp_valid, n_rsp_valid;

    logic [3:0]      r_mode;
    logic [31:0]     r_val;
    logic            r_force;
    logic [7:0]      r_reload;
    logic [2:0]      r_bit;
    logic [FW-1:0]   r_fidx;
    logic [AW-1:0]   r_bidx;
    logic            r_chg, n_chg;
    logic [7:0]      r_rd, n_rd;
    ctdp_pkg::t_rsp  r_rsp;

    logic            w_acc;
    logic            w_load;
    logic [1:0]      w_span;
    logic [11:0]     w_bstart12;
    logic [11:0]     w_fbit12;
    logic [11:0]     w_fbyte12;
    logic [AW-1:0]   w_bstart;
    logic [AW-1:0]   w_bnext;
    logic [AW-1:0]   w_brd_addr;
    logic [FW-1:0]   w_fidx;

    logic            w_bwe;
    logic [AW-1:0]   w_bwa;
    logic [8:0]      w_bwd;
    logic            w_fwe;
    logic [FW-1:0]   w_fwa;
    logic [15:0]     w_fwd;
    logic [3:0]      w_inc;
    logic [3:0]      w_dec;

    logic [7:0]      w_old_data;
    logic            w_old_mark;
    logic [7:0]      w_fs;
    logic [7:0]      w_fm;
    logic [7:0]      w_msk;
    logic [7:0]      w_newbit;
    logic [7:0]      w_v;

    assign o_req_stall = (r_state != ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign w_acc  = i_req_valid && (r_state == ST_IDLE);
    assign w_load = (r_state == ST_DONE) && (!r_rsp_valid || !i_rsp_stall);

    // Multi-byte writes start at the highest address and walk down.
    always_comb begin
        case (i_req.mode)
            ctdp_pkg::MODE_WORD_WR: w_span = 2'd1;
            ctdp_pkg::MODE_LONG_WR: w_span = 2'd3;
            default:                w_span = 2'd0;
        endcase
    end

    assign w_bstart12 = wrap_index({2'b00, i_req.address} + {8'd0, w_span},
                                   BYTE_DEPTH, RECIP_B);
    assign w_fbit12   = wrap_index({2'b00, i_req.address}, FLAG_BITS, RECIP_FB);
    assign w_fbyte12  = wrap_index({2'b00, i_req.address}, FLAG_BYTES, RECIP_FY);
    assign w_bstart   = w_bstart12[AW-1:0];
    assign w_fidx     = (i_req.mode == ctdp_pkg::MODE_BIT_WR) ? w_fbit12[FW+2:3]
                                                              : w_fbyte12[FW-1:0];
    assign w_bnext    = (r_bidx == '0) ? AW'(BYTE_DEPTH - 1) : r_bidx - AW'(1);
    assign w_brd_addr = (r_state == ST_IDLE) ? w_bstart : w_bnext;

    assign w_old_data = r_bmem_q[7:0];
    assign w_old_mark = r_bmem_q[8];
    assign w_fs       = r_fmem_q[15:8];
    assign w_fm       = r_fmem_q[7:0];
    assign w_v        = r_val[7:0];
    assign w_msk      = 8'b1 << r_bit;
    assign w_newbit   = r_val[0] ? (w_fs | w_msk) : (w_fs & ~w_msk);

    // Read-modify-write of the entry read in the previous cycle. Reads of a
    // new request start only after the previous request's writes landed.
    always_comb begin
        w_bwe = 1'b0;
        w_bwa = r_bidx;
        w_bwd = r_bmem_q;
        w_fwe = 1'b0;
        w_fwa = r_fidx;
        w_fwd = r_fmem_q;
        w_inc = 4'd0;
        w_dec = 4'd0;
        n_chg = r_chg;
        n_rd  = r_rd;
        if (r_state == ST_CLEAR) begin
            w_bwe = ({1'b0, r_clr} < (CLRW + 1)'(BYTE_DEPTH));
            w_bwa = r_clr[AW-1:0];
            w_bwd = '0;
            w_fwe = ({1'b0, r_clr} < (CLRW + 1)'(FLAG_DEPTH));
            w_fwa = r_clr[FW-1:0];
            w_fwd = '0;
        end else if (r_state == ST_WORK) begin
            unique case (r_mode) inside
                ctdp_pkg::MODE_BYTE_WR, ctdp_pkg::MODE_WORD_WR,
                ctdp_pkg::MODE_LONG_WR: begin
                    if (r_force || (w_v != w_old_data)) begin
                        w_bwe = 1'b1;
                        w_bwd = {1'b1, w_v};
                        n_chg = 1'b1;
                        w_inc = {3'd0, !w_old_mark};
                    end
                end
                ctdp_pkg::MODE_BIT_WR: begin
                    if (r_force || (w_newbit != w_fs)) begin
                        w_fwe = 1'b1;
                        w_fwd = {w_newbit, w_fm | w_msk};
                        n_chg = 1'b1;
                        w_inc = {3'd0, (w_fm & w_msk) == 8'd0};
                    end
                end
                ctdp_pkg::MODE_FBYTE_WR: begin
                    if (r_force || (w_v != w_fs)) begin
                        w_fwe = 1'b1;
                        w_fwd = {w_v, w_fm | (w_fs ^ w_v)};
                        n_chg = 1'b1;
                        w_inc = popcount8((w_fs ^ w_v) & ~w_fm);
                    end
                end
                ctdp_pkg::MODE_FBYTE_FTCH: begin
                    n_rd  = w_fs;
                    w_fwe = 1'b1;
                    w_fwd = {r_reload, 8'd0};
                    w_dec = popcount8(w_fm);
                end
                ctdp_pkg::MODE_BYTE_RD: begin
                    n_rd  = w_old_data;
                    n_chg = w_old_mark;
                end
                ctdp_pkg::MODE_CLEAR_MARK: begin
                    w_bwe = 1'b1;
                    w_bwd = {1'b0, w_old_data};
                    w_dec = {3'd0, w_old_mark};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bwe) begin
            r_bmem[w_bwa] <= w_bwd;
        end
        r_bmem_q <= r_bmem[w_brd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_fwe) begin
            r_fmem[w_fwa] <= w_fwd;
        end
        r_fmem_q <= r_fmem[w_fidx];
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_left      = r_left;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        n_count     = r_count + CW'(w_inc) - CW'(w_dec);
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + CLRW'(1);
                if (r_clr == CLRW'(MAXD - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_WORK;
                    n_left  = w_span;
                end
            end
            ST_WORK: begin
                if (r_left == 2'd0) begin
                    n_state = ST_DONE;
                end else begin
                    n_left = r_left - 2'd1;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state     = ST_IDLE;
                    n_rsp_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_left      <= 2'd0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_left      <= n_left;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode   <= i_req.mode;
            r_val    <= i_req.value;
            r_force  <= i_req.force_req;
            r_reload <= i_req.reload_value;
            r_bit    <= w_fbit12[2:0];
            r_fidx   <= w_fidx;
            r_bidx   <= w_bstart;
            r_chg    <= 1'b0;
            r_rd     <= 8'd0;
        end else if (r_state == ST_WORK) begin
            r_val  <= {8'd0, r_val[31:8]};
            r_bidx <= w_bnext;
            r_chg  <= n_chg;
            r_rd   <= n_rd;
        end
        if (w_load) begin
            r_rsp.read_data   <= r_rd;
            r_rsp.changed     <= r_chg;
            r_rsp.any_changed <= (r_count != '0);
        end
    end

    `ASSERT_NEXT(a_accept_starts_work, i_clk, i_rst_n, w_acc, r_state == ST_WORK, "accepted request did not start work")
    `ASSERT_NOW(a_left_only_in_work, i_clk, i_rst_n, r_left != 2'd0, r_state == ST_WORK, "byte counter busy outside work")
    `ASSERT_NEXT(a_load_gives_beat, i_clk, i_rst_n, w_load, r_rsp_valid && (r_state == ST_IDLE), "finished response not presented")
    `ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(BYTE_DEPTH + FLAG_BITS), "pending mark count out of range")
    `ASSERT_NOW(a_no_write_when_idle, i_clk, i_rst_n, (r_state == ST_IDLE) || (r_state == ST_DONE), !w_bwe && !w_fwe, "memory written outside clear or work")

endmodule

`default_nettype wire

// File: tb/sv/change_tracking_data_pool_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// change_tracking_data_pool_unit_tb
// Self-checking bench for the change tracking data pool. A shadow copy of the
// byte area, the flag area and their change marks works out the response of
// every request as it is accepted. A monitor compares each response beat,
// field by field, against the oldest outstanding answer. Directed cases cover
// the address wrap, forced writes, fetches and unused modes. Random traffic
// then runs in segments, each ending with a sweep that clears every mark.
// ============================================================================

module change_tracking_data_pool_unit_tb;

    localparam int BYTES      = ctdp_pkg::BYTE_DEPTH_DEF;
    localparam int FLAG_BYTES = ctdp_pkg::FLAG_BITS_DEF / 8;
    localparam int SEGMENTS   = 8;
    localparam int SEG_ITEMS  = 70;

    logic clk;
    logic rst_n = 1'b0;

    logic           req_valid = 1'b0;
    logic           req_stall;
    ctdp_pkg::t_req req_bus   = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    ctdp_pkg::t_rsp rsp_bus;

    // Shadow of the block's storage, updated in acceptance order.
    logic [7:0]  byte_shadow [0:BYTES-1];
    bit          byte_dirty  [0:BYTES-1];
    logic [7:0]  flag_shadow [0:FLAG_BYTES-1];
    logic [7:0]  flag_dirty  [0:FLAG_BYTES-1];
    int unsigned dirty_total;

    ctdp_pkg::t_rsp answers_q [$];
    ctdp_pkg::t_rsp front_rsp;
    int unsigned    mismatch_count  = 0;
    int unsigned    requests_sent   = 0;
    int unsigned    answers_checked = 0;
    bit             quiet           = 1'b0;

    change_tracking_data_pool_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req_bus),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp_bus)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shadow storage
    // ------------------------------------------------------------------------
    function automatic void set_flag_dirty(int unsigned idx, logic [7:0] marks);
        dirty_total = dirty_total - $countones(flag_dirty[idx]) + $countones(marks);
        flag_dirty[idx] = marks;
    endfunction

    function automatic bit shadow_byte_write(int unsigned addr, logic [7:0] data, bit frc);
        int unsigned a = addr % BYTES;
        if (frc || data != byte_shadow[a]) begin
            byte_shadow[a] = data;
            if (!byte_dirty[a]) begin
                byte_dirty[a] = 1'b1;
                dirty_total++;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic ctdp_pkg::t_rsp apply_pool_request(input ctdp_pkg::t_req r);
        ctdp_pkg::t_rsp rsp;
        int unsigned    bit_idx;
        int unsigned    fidx;
        int unsigned    a;
        logic [7:0]     msk;
        logic [7:0]     oldv;
        logic [7:0]     newv;
        bit             c0, c1, c2, c3;
        rsp = '0;
        a = r.address % BYTES;
        fidx = r.address % FLAG_BYTES;
        case (r.mode)
            ctdp_pkg::MODE_BYTE_WR: begin
                rsp.changed = shadow_byte_write(a, r.value[7:0], r.force_req);
            end
            ctdp_pkg::MODE_WORD_WR: begin
                c0 = shadow_byte_write(a, r.value[15:8], r.force_req);
                c1 = shadow_byte_write(a + 1, r.value[7:0], r.force_req);
                rsp.changed = c0 | c1;
            end
            ctdp_pkg::MODE_LONG_WR: begin
                c3 = shadow_byte_write(a + 3, r.value[7:0], r.force_req);
                c2 = shadow_byte_write(a + 2, r.value[15:8], r.force_req);
                c1 = shadow_byte_write(a + 1, r.value[23:16], r.force_req);
                c0 = shadow_byte_write(a, r.value[31:24], r.force_req);
                rsp.changed = c0 | c1 | c2 | c3;
            end
            ctdp_pkg::MODE_BIT_WR: begin
                bit_idx = r.address % ctdp_pkg::FLAG_BITS_DEF;
                fidx = bit_idx >> 3;
                msk = 8'h01 << (bit_idx & 7);
                oldv = flag_shadow[fidx];
                newv = r.value[0] ? (oldv | msk) : (oldv & ~msk);
                if (r.force_req || newv != oldv) begin
                    flag_shadow[fidx] = newv;
                    set_flag_dirty(fidx, flag_dirty[fidx] | msk);
                    rsp.changed = 1'b1;
                end
            end
            ctdp_pkg::MODE_FBYTE_WR: begin
                if (r.force_req || r.value[7:0] != flag_shadow[fidx]) begin
                    // Only bits that really differ get a mark, forced or not.
                    set_flag_dirty(fidx, flag_dirty[fidx] | (flag_shadow[fidx] ^ r.value[7:0]));
                    flag_shadow[fidx] = r.value[7:0];
                    rsp.changed = 1'b1;
                end
            end
            ctdp_pkg::MODE_FBYTE_FTCH: begin
                rsp.read_data = flag_shadow[fidx];
                flag_shadow[fidx] = r.reload_value;
                set_flag_dirty(fidx, 8'h00);
            end
            ctdp_pkg::MODE_BYTE_RD: begin
                rsp.read_data = byte_shadow[a];
                rsp.changed = byte_dirty[a];
            end
            ctdp_pkg::MODE_CLEAR_MARK: begin
                if (byte_dirty[a]) begin
                    byte_dirty[a] = 1'b0;
                    dirty_total--;
                end
            end
            default: begin
            end
        endcase
        rsp.any_changed = (dirty_total != 0);
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    function automatic ctdp_pkg::t_req pool_req(logic [3:0] mode, logic [7:0] addr,
                                                logic [31:0] data, bit frc,
                                                logic [7:0] reload);
        ctdp_pkg::t_req r;
        r.mode         = mode;
        r.address      = addr;
        r.value        = data;
        r.force_req    = frc;
        r.reload_value = reload;
        return r;
    endfunction

    task automatic push_request(input ctdp_pkg::t_req r);
        while (!quiet && $urandom_range(0, 99) < 11) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_bus   <= r;
        @(posedge clk);
        while (req_stall !== 1'b0) @(posedge clk);
        answers_q.push_back(apply_pool_request(r));
        requests_sent++;
    endtask

    // Clears every pending mark, so the pending indication must drop to zero.
    task automatic sweep_marks();
        for (int a = 0; a < BYTES; a++) begin
            if (byte_dirty[a]) begin
                push_request(pool_req(ctdp_pkg::MODE_CLEAR_MARK, 8'(a), $urandom,
                                      1'b0, 8'h00));
            end
        end
        for (int i = 0; i < FLAG_BYTES; i++) begin
            if (flag_dirty[i] != 0) begin
                push_request(pool_req(ctdp_pkg::MODE_FBYTE_FTCH,
                                      8'(i + FLAG_BYTES * $urandom_range(0, 7)),
                                      $urandom, 1'($urandom_range(0, 1)),
                                      8'($urandom_range(0, 255))));
            end
        end
        push_request(pool_req(ctdp_pkg::MODE_CHECK, 8'($urandom_range(0, 255)), $urandom,
                              1'b0, 8'h00));
    endtask

    // ------------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        rsp_stall <= !quiet && ($urandom_range(0, 99) < 11);
    end

    always @(posedge clk) begin
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall) begin
            if (answers_q.size() == 0) begin
                $error("response beat with nothing outstanding: %p", rsp_bus);
                mismatch_count++;
            end else begin
                front_rsp = answers_q.pop_front();
                answers_checked++;
                if (rsp_bus.read_data !== front_rsp.read_data) begin
                    $error("read_data: expected %02h, got %02h",
                           front_rsp.read_data, rsp_bus.read_data);
                    mismatch_count++;
                end
                if (rsp_bus.changed !== front_rsp.changed) begin
                    $error("changed: expected %0b, got %0b", front_rsp.changed, rsp_bus.changed);
                    mismatch_count++;
                end
                if (rsp_bus.any_changed !== front_rsp.any_changed) begin
                    $error("any_changed: expected %0b, got %0b",
                           front_rsp.any_changed, rsp_bus.any_changed);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_byte_area();
        push_request(pool_req(ctdp_pkg::MODE_BYTE_WR, 8'd0, 32'h0000_0000, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_BYTE_WR, 8'd0, 32'h0000_0000, 1'b1, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_BYTE_WR, 8'd255, 32'hFFFF_FFFF, 1'b0, 8'hFF));
        push_request(pool_req(ctdp_pkg::MODE_BYTE_RD, 8'd255, 32'h0000_0000, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_CLEAR_MARK, 8'd255, 32'h0000_0000, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_BYTE_RD, 8'd255, 32'h0000_0000, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_CLEAR_MARK, 8'd0, 32'h0000_0000, 1'b0, 8'h00));
        // Word and long writes that run off the top of the area wrap to zero.
        push_request(pool_req(ctdp_pkg::MODE_WORD_WR, 8'd255, 32'h1234_A55A, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_LONG_WR, 8'd254, 32'h0102_0304, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_LONG_WR, 8'd254, 32'h0102_0304, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_LONG_WR, 8'd254, 32'h0102_0304, 1'b1, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_BYTE_RD, 8'd1, 32'hFFFF_FFFF, 1'b1, 8'hFF));
    endtask

    task automatic test_flag_area();
        push_request(pool_req(ctdp_pkg::MODE_BIT_WR, 8'd255, 32'hFFFF_FFFF, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_BIT_WR, 8'd255, 32'h0000_0001, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_BIT_WR, 8'd0, 32'hFFFF_FFFE, 1'b1, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_FBYTE_WR, 8'd255, 32'h0000_0080, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_FBYTE_WR, 8'd31, 32'h0000_0080, 1'b1, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_FBYTE_WR, 8'd32, 32'h0000_00FF, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_FBYTE_FTCH, 8'd0, 32'h0000_0000, 1'b0, 8'hFF));
        push_request(pool_req(ctdp_pkg::MODE_FBYTE_FTCH, 8'd31, 32'h0000_0000, 1'b0, 8'h00));
        push_request(pool_req(ctdp_pkg::MODE_CHECK, 8'd0, 32'h0000_0000, 1'b0, 8'h00));
    endtask

    task automatic test_unused_modes();
        push_request(pool_req(4'd9, 8'd0, 32'hFFFF_FFFF, 1'b1, 8'hFF));
        push_request(pool_req(4'd12, 8'd128, 32'h8000_0000, 1'b0, 8'h80));
        push_request(pool_req(4'd15, 8'd255, 32'hFFFF_FFFF, 1'b1, 8'hFF));
    endtask

    task automatic test_random_traffic();
        ctdp_pkg::t_req r;
        logic [7:0]     a;
        logic [7:0]     byte_base;
        logic [7:0]     bit_base;
        int unsigned    sel;
        bit             narrow;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // One segment runs with no idling on either side.
            quiet     = (seg == 3);
            narrow    = (seg != 2 && seg != 6);
            byte_base = 8'($urandom_range(0, 255));
            bit_base  = 8'($urandom_range(0, 255));
            for (int n = 0; n < SEG_ITEMS; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 15)      r.mode = ctdp_pkg::MODE_BYTE_WR;
                else if (sel < 25) r.mode = ctdp_pkg::MODE_WORD_WR;
                else if (sel < 35) r.mode = ctdp_pkg::MODE_LONG_WR;
                else if (sel < 50) r.mode = ctdp_pkg::MODE_BIT_WR;
                else if (sel < 60) r.mode = ctdp_pkg::MODE_FBYTE_WR;
                else if (sel < 68) r.mode = ctdp_pkg::MODE_FBYTE_FTCH;
                else if (sel < 83) r.mode = ctdp_pkg::MODE_BYTE_RD;
                else if (sel < 88) r.mode = ctdp_pkg::MODE_CHECK;
                else if (sel < 96) r.mode = ctdp_pkg::MODE_CLEAR_MARK;
                else               r.mode = 4'($urandom_range(9, 15));
                r.value        = $urandom;
                r.force_req    = ($urandom_range(0, 99) < 20);
                r.reload_value = 8'($urandom_range(0, 255));
                if (!narrow) begin
                    r.address = 8'($urandom_range(0, 255));
                end else if (r.mode == ctdp_pkg::MODE_BIT_WR) begin
                    r.address = bit_base + 8'($urandom_range(0, 15));
                end else if (r.mode == ctdp_pkg::MODE_FBYTE_WR ||
                             r.mode == ctdp_pkg::MODE_FBYTE_FTCH) begin
                    r.address = 8'(((bit_base >> 3) + $urandom_range(0, 1)) % FLAG_BYTES
                                   + FLAG_BYTES * $urandom_range(0, 7));
                end else begin
                    r.address = byte_base + 8'($urandom_range(0, 7));
                end
                // Rewrite what is already stored now and then, to hit the no-change path.
                a = r.address;
                if ($urandom_range(0, 99) < 35) begin
                    case (r.mode)
                        ctdp_pkg::MODE_BYTE_WR: r.value[7:0] = byte_shadow[a];
                        ctdp_pkg::MODE_WORD_WR: begin
                            r.value[15:0] = {byte_shadow[a], byte_shadow[a + 8'd1]};
                        end
                        ctdp_pkg::MODE_LONG_WR: begin
                            r.value = {byte_shadow[a], byte_shadow[a + 8'd1],
                                       byte_shadow[a + 8'd2], byte_shadow[a + 8'd3]};
                        end
                        ctdp_pkg::MODE_FBYTE_WR: r.value[7:0] = flag_shadow[a % FLAG_BYTES];
                        default: begin
                        end
                    endcase
                end
                push_request(r);
            end
            sweep_marks();
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int a = 0; a < BYTES; a++) begin
            byte_shadow[a] = 8'h00;
            byte_dirty[a]  = 1'b0;
        end
        for (int i = 0; i < FLAG_BYTES; i++) begin
            flag_shadow[i] = 8'h00;
            flag_dirty[i]  = 8'h00;
        end
        dirty_total = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_byte_area();
        test_flag_area();
        test_unused_modes();
        test_random_traffic();

        req_valid <= 1'b0;
        while (answers_q.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Ran %0d requests: directed byte, word, long, flag and unused-mode cases,",
                 requests_sent);
        $display("then %0d random segments with mark sweeps; %0d responses compared.",
                 SEGMENTS, answers_checked);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
